// ===== sv/sddf_pkg.sv =====
// Package for the signed decimal digit formatter.
// Holds the symbol codes, the conversion constants and the record type that the
// front, queue and back modules share. Depends on nothing.
package sddf_pkg;

    localparam int DEFAULT_MAX_DIGITS = 16;
    localparam int DEC_DIGITS         = 10;
    localparam int DIGIT_IDX_W        = 4;
    localparam int DCOUNT_W           = 5;
    localparam int POINT_W            = 5;

    localparam logic [3:0]          SYM_BLANK         = 4'd10;
    localparam logic [3:0]          SYM_MINUS         = 4'd11;
    localparam logic [DCOUNT_W-1:0] PLACE_COUNT_RESET = 5'd4;

    // x / 10 == (x * RECIP10) >> 35 for every 32-bit unsigned x.
    localparam logic [63:0] RECIP10     = 64'h0000_0000_CCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef logic [DEC_DIGITS-1:0][3:0] dec_digits_t;

    // One converted number waiting to be shown.
    typedef struct packed {
        dec_digits_t        digits;   // digit 0 is the least significant
        logic [3:0]         used;     // significant digits, 1..10
        logic               neg;
        logic               fill;
        logic [POINT_W-1:0] point;
    } conv_rec_t;

endpackage

// ===== sv/sddf_front.sv =====
// Front part of the digit formatter: accepts a transaction and converts the
// magnitude to decimal, one digit per cycle by reciprocal multiplication.
// Depends on sddf_pkg.
module sddf_front
    import sddf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        value,
    input  logic               zero_fill,
    input  logic [POINT_W-1:0] point_position,
    output logic               push_valid,
    input  logic               push_ready,
    output conv_rec_t          push_rec
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [31:0]            mag_reg;
    logic [DIGIT_IDX_W-1:0] cnt_reg;
    dec_digits_t            digits_reg;
    logic [3:0]             used_reg;
    logic                   neg_reg;
    logic                   fill_reg;
    logic [POINT_W-1:0]     point_reg;

    logic        accept;
    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] quot10;
    logic [3:0]  rem;
    logic        last_step;

    assign in_stall = !((state_reg == ST_IDLE) ||
                        ((state_reg == ST_DONE) && push_ready));
    assign accept   = in_valid && !in_stall;

    assign prod      = {32'd0, mag_reg} * RECIP10;
    assign quot      = {3'd0, prod[63:RECIP_SHIFT]};
    assign quot10    = (quot << 3) + (quot << 1);
    assign rem       = 4'(mag_reg - quot10);
    assign last_step = (quot == 32'd0) || (cnt_reg == DIGIT_IDX_W'(DEC_DIGITS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (last_step)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (accept)
                    state_next = ST_CONV;
                else if (push_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg   <= value[31] ? (32'd0 - value) : value;
            neg_reg   <= value[31];
            fill_reg  <= zero_fill;
            point_reg <= point_position;
            cnt_reg   <= '0;
        end
        else if (state_reg == ST_CONV)
        begin
            digits_reg[cnt_reg] <= rem;
            mag_reg             <= quot;
            if (last_step)
                used_reg <= 4'(cnt_reg) + 4'd1;
            else
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign push_valid      = (state_reg == ST_DONE);
    assign push_rec.digits = digits_reg;
    assign push_rec.used   = used_reg;
    assign push_rec.neg    = neg_reg;
    assign push_rec.fill   = fill_reg;
    assign push_rec.point  = point_reg;

endmodule

// ===== sv/sddf_queue.sv =====
// Two-entry queue of converted records between the front and back parts.
// Depends on sddf_pkg.
module sddf_queue
    import sddf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  conv_rec_t push_rec,
    output logic      pop_valid,
    input  logic      pop_ready,
    output conv_rec_t pop_rec
);

    conv_rec_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_rec    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

// ===== sv/sddf_back.sv =====
// Back part of the digit formatter: takes converted records from the queue and
// sends one symbol per display place, leftmost first, through an output register.
// Depends on sddf_pkg.
module sddf_back
    import sddf_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [DCOUNT_W-1:0] place_count,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  conv_rec_t           pop_rec,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          symbol,
    output logic                point_on,
    output logic                last_digit
);

    localparam int CW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    conv_rec_t           rec_reg;
    logic [DCOUNT_W-1:0] n_reg;
    logic [CW-1:0]       pos_reg;
    logic                active_reg;
    logic                out_valid_reg;
    logic [3:0]          symbol_reg;
    logic                point_reg;
    logic                last_reg;

    logic [DCOUNT_W-1:0] n_eff;
    logic [DCOUNT_W-1:0] pos_w;
    logic [DCOUNT_W-1:0] used_w;
    logic [DCOUNT_W-1:0] used_eff;
    logic                advance;
    logic                is_last;
    logic                load;
    logic [3:0]          sym_cur;
    logic                point_cur;

    always_comb
    begin
        if (place_count == '0)
            n_eff = DCOUNT_W'(1);
        else if (place_count > DCOUNT_W'(MAX_DIGITS))
            n_eff = DCOUNT_W'(MAX_DIGITS);
        else
            n_eff = place_count;
    end

    assign pos_w    = DCOUNT_W'(pos_reg);
    assign used_w   = DCOUNT_W'(rec_reg.used);
    assign used_eff = (used_w < n_reg) ? used_w : n_reg;
    assign is_last  = (pos_reg == '0);

    // pos_reg counts places from the right; the point counts from the left.
    always_comb
    begin
        if (pos_w < used_eff)
            sym_cur = rec_reg.digits[pos_w[DIGIT_IDX_W-1:0]];
        else if (rec_reg.neg && (pos_w == used_eff))
            sym_cur = SYM_MINUS;
        else if (rec_reg.fill)
            sym_cur = 4'd0;
        else
            sym_cur = SYM_BLANK;
    end

    assign point_cur = (rec_reg.point == (n_reg - pos_w));

    assign advance   = !out_valid_reg || !out_stall;
    assign load      = advance && (!active_reg || is_last);
    assign pop_ready = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= active_reg;
            if (load)
                active_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            symbol_reg <= sym_cur;
            point_reg  <= point_cur;
            last_reg   <= is_last;
            if (load)
            begin
                rec_reg <= pop_rec;
                n_reg   <= n_eff;
                pos_reg <= CW'(n_eff - DCOUNT_W'(1));
            end
            else
            begin
                pos_reg <= pos_reg - 1'b1;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign symbol     = symbol_reg;
    assign point_on   = point_reg;
    assign last_digit = last_reg;

endmodule

// ===== sv/signed_decimal_digit_formatter.sv =====
// Top level of the signed decimal digit formatter.
// Instantiates sddf_front, sddf_queue and sddf_back and holds the place count
// register. Depends on sddf_pkg.
//
// The input channel (in_valid, in_stall) carries one transaction per number:
// value, zero_fill and point_position. The output channel (out_valid, out_stall)
// carries one transaction per display place, leftmost first: symbol (0 to 9
// digit, 10 blank, 11 minus), point_on, and last_digit on the rightmost place.
// The user must write the place count with cfg_write and cfg_data only while
// the block is idle; the block itself does not enforce this. 0 acts as 1 and
// counts above MAX_DIGITS act as MAX_DIGITS. The front converts one decimal
// digit per cycle by a multiply with the reciprocal of ten; a finished number
// passes through a queue entry and the back's record register before its
// first symbol reaches the output register. The back sends one symbol per
// cycle while the receiver does not stall, and the two-entry queue lets the
// front convert the next number meanwhile.
// Reset clears all control state and sets the place count to 4. When the
// receiver stalls, the output register holds its transaction, the queue fills,
// and then in_stall rises toward the sender.
module signed_decimal_digit_formatter
    import sddf_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [DCOUNT_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        value,
    input  logic               zero_fill,
    input  logic [POINT_W-1:0] point_position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         symbol,
    output logic               point_on,
    output logic               last_digit
);

    logic [DCOUNT_W-1:0] place_count_reg;

    logic      push_valid;
    logic      push_ready;
    conv_rec_t push_rec;
    logic      pop_valid;
    logic      pop_ready;
    conv_rec_t pop_rec;

    // The place count is the only configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            place_count_reg <= PLACE_COUNT_RESET;
        else if (cfg_write)
            place_count_reg <= cfg_data;
    end

    // The front accepts numbers and produces their decimal digits.
    sddf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .value          (value),
        .zero_fill      (zero_fill),
        .point_position (point_position),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_rec       (push_rec)
    );

    // The queue decouples conversion from emission so each side stalls alone.
    sddf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    // The back lays the digits out on the display places.
    sddf_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .place_count (place_count_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_rec     (pop_rec),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .symbol      (symbol),
        .point_on    (point_on),
        .last_digit  (last_digit)
    );

endmodule

// ===== sv/sddf_checker.sv =====
// Port-level checker for the signed decimal digit formatter, bound to the top.
// Depends on sddf_pkg.
module sddf_checker
    import sddf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] symbol,
    input logic       point_on,
    input logic       last_digit
);

    // A stalled output transaction holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(symbol) &&
        $stable(point_on) && $stable(last_digit))
        else $error("output transaction changed while stalled");

    // Symbols stay within the digit, blank and minus codes.
    a_sym_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> symbol <= SYM_MINUS)
        else $error("symbol code out of range");

    // The minus sign always has a digit to its right.
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (symbol == SYM_MINUS) |-> !last_digit)
        else $error("minus sign on the rightmost place");

    // A fresh transaction starts a conversion, so the input stalls next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled during conversion");

endmodule

bind signed_decimal_digit_formatter sddf_checker u_sddf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .symbol     (symbol),
    .point_on   (point_on),
    .last_digit (last_digit)
);

// ===== tb/sv/tb_sddf_scoreboard_pkg.sv =====
// Scoreboard for the signed decimal digit formatter testbench.
// Holds the expected display places and the place count copy used to predict
// them. Depends on sddf_pkg.
package tb_sddf_scoreboard_pkg;

    import sddf_pkg::*;

    // One display place as the block sends it.
    typedef struct packed {
        logic [3:0] symbol;
        logic       point_on;
        logic       last_digit;
    } display_place_t;

    class digit_scoreboard;

        logic [DCOUNT_W-1:0] count_setting;
        display_place_t      expected_places[$];
        int                  mismatches;
        int                  numbers_seen;
        int                  places_checked;

        function new();
            count_setting  = PLACE_COUNT_RESET;
            mismatches     = 0;
            numbers_seen   = 0;
            places_checked = 0;
        endfunction

        function void set_place_count(logic [DCOUNT_W-1:0] count);
            count_setting = count;
        endfunction

        function int pending();
            return expected_places.size();
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH @%0t: %s", $time, what);
            mismatches++;
        endtask

        // Formats one accepted number into the places it must produce.
        function void note_number(logic [31:0] number, logic fill, logic [POINT_W-1:0] point);
            logic [3:0]     digit_sym[DEFAULT_MAX_DIGITS];
            logic [31:0]    magnitude;
            logic           negative;
            int             places;
            int             used;
            int             first_digit;
            display_place_t place;

            places = count_setting;
            if (places < 1)
                places = 1;
            if (places > DEFAULT_MAX_DIGITS)
                places = DEFAULT_MAX_DIGITS;

            negative  = number[31];
            magnitude = negative ? (~number + 32'd1) : number;

            for (int i = 0; i < places; i++)
                digit_sym[i] = SYM_BLANK;

            used = 0;
            if (magnitude == 32'd0)
            begin
                digit_sym[places - 1] = 4'd0;
                used = 1;
            end
            else
            begin
                while (magnitude != 32'd0 && used < places)
                begin
                    digit_sym[places - 1 - used] = 4'(magnitude % 32'd10);
                    magnitude = magnitude / 32'd10;
                    used++;
                end
            end

            first_digit = places - used;
            if (fill)
            begin
                for (int i = 0; i < first_digit; i++)
                    digit_sym[i] = 4'd0;
            end
            // The sign only shows when a place is left of the digits.
            if (negative && first_digit > 0)
                digit_sym[first_digit - 1] = SYM_MINUS;

            for (int i = 0; i < places; i++)
            begin
                place.symbol     = digit_sym[i];
                place.point_on   = (int'(point) == i + 1);
                place.last_digit = (i == places - 1);
                expected_places.push_back(place);
            end
            numbers_seen++;
        endfunction

        task check_place(logic [3:0] symbol, logic point_on, logic last_digit);
            display_place_t want;

            if (expected_places.size() == 0)
            begin
                report_mismatch($sformatf("unexpected place symbol=%0d point=%0b last=%0b",
                                          symbol, point_on, last_digit));
            end
            else
            begin
                want = expected_places.pop_front();
                places_checked++;
                if (symbol !== want.symbol)
                    report_mismatch($sformatf("symbol %0d, expected %0d",
                                              symbol, want.symbol));
                if (point_on !== want.point_on)
                    report_mismatch($sformatf("point_on %0b, expected %0b",
                                              point_on, want.point_on));
                if (last_digit !== want.last_digit)
                    report_mismatch($sformatf("last_digit %0b, expected %0b",
                                              last_digit, want.last_digit));
            end
        endtask

    endclass

endpackage

// ===== tb/sv/tb_signed_decimal_digit_formatter.sv =====
// Top-level testbench for the signed decimal digit formatter.
// Drives numbers and place count settings, checks every display place against
// the scoreboard. Depends on sddf_pkg, tb_sddf_scoreboard_pkg and the RTL.
module tb_signed_decimal_digit_formatter;

    timeunit 1ns;
    timeprecision 1ps;

    import sddf_pkg::*;
    import tb_sddf_scoreboard_pkg::*;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                cfg_write      = 1'b0;
    logic [DCOUNT_W-1:0] cfg_data       = '0;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    logic [31:0]         value          = '0;
    logic                zero_fill      = 1'b0;
    logic [POINT_W-1:0]  point_position = '0;
    logic                out_valid;
    logic                out_stall      = 1'b0;
    logic [3:0]          symbol;
    logic                point_on;
    logic                last_digit;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int              send_idle_pct  = 23;
    int              recv_stall_pct = 59;
    // Set while the receiver holds off for a long stretch.
    bit              hold_on        = 1'b0;
    digit_scoreboard sb             = new();

    // Place count settings of the random phases. 0 acts as 1 and everything
    // above sixteen acts as sixteen; 17 and 31 exercise the upper clamp, and 31
    // drives every bit of the register high.
    localparam int PHASES = 8;
    localparam logic [DCOUNT_W-1:0] PHASE_COUNT[PHASES] =
        '{5'd31, 5'd1, 5'd7, 5'd16, 5'd10, 5'd17, 5'd4, 5'd2};
    localparam int ITEMS_PER_PHASE = 49;

    signed_decimal_digit_formatter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .value          (value),
        .zero_fill      (zero_fill),
        .point_position (point_position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .symbol         (symbol),
        .point_on       (point_on),
        .last_digit     (last_digit)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver decides its stall at the falling edge, so the value is
    // settled long before the rising edge that samples the transaction.
    always @(negedge clk)
    begin
        if (hold_on)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Every accepted output transaction is compared with the oldest expected
    // display place. Reads here see the values from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_place(symbol, point_on, last_digit);
    end

    // Offers one number and waits until the block takes it. Idle cycles come
    // first, with valid low; once valid is high it stays high, with a steady
    // payload, until the transaction is accepted.
    task automatic send_number(logic [31:0] number, logic fill, logic [POINT_W-1:0] point);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        value          <= number;
        zero_fill      <= fill;
        point_position <= point;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_number(number, fill, point);
    endtask

    // Drops valid and waits until every expected display place has arrived.
    // Each number produces at least one place, so the block is idle then.
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Writes the place count register; only called while the block is idle.
    task automatic write_place_count(logic [DCOUNT_W-1:0] count);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= count;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.set_place_count(count);
    endtask

    // The receiver refuses everything while this task keeps hold_on set and the
    // sender keeps offering; the queue fills and in_stall rises.
    task automatic hold_receiver(int cycles);
        hold_on = 1'b1;
        repeat (cycles) @(posedge clk);
        hold_on = 1'b0;
    endtask

    // Most random numbers get a chosen count of significant digits so that
    // every length from one to ten shows up often; the rest are raw 32-bit
    // patterns and the corner values.
    function automatic logic [31:0] random_number();
        longint unsigned modulus;
        longint unsigned raw;
        logic [31:0]     magnitude;

        case ($urandom_range(9))
            0: random_number = $urandom;
            1:
            begin
                case ($urandom_range(3))
                    0:       random_number = 32'h8000_0000;
                    1:       random_number = 32'h7FFF_FFFF;
                    2:       random_number = 32'h0000_0000;
                    default: random_number = 32'hFFFF_FFFF;
                endcase
            end
            default:
            begin
                modulus = 1;
                repeat ($urandom_range(1, 10)) modulus = modulus * 10;
                raw       = $urandom;
                magnitude = 32'(raw % modulus);
                random_number = $urandom_range(1) ? (~magnitude + 32'd1) : magnitude;
            end
        endcase
    endfunction

    task automatic run_random(int count);
        repeat (count)
            send_number(random_number(), 1'($urandom_range(1)),
                        POINT_W'($urandom_range(16)));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed numbers at the reset place count of four: zero, sign
        // placement over a fill zero, no room for the sign, truncation to the
        // low digits, the most negative value and points inside and beyond
        // the place count.
        send_number(32'd0,          1'b0, 5'd0);
        send_number(32'd0,          1'b1, 5'd4);
        send_number(32'd5,          1'b0, 5'd1);
        send_number(-32'sd5,        1'b1, 5'd2);
        send_number(-32'sd123,      1'b0, 5'd5);
        send_number(-32'sd1234,     1'b1, 5'd3);
        send_number(32'd12345,      1'b0, 5'd4);
        send_number(32'h8000_0000,  1'b1, 5'd0);
        send_number(32'h7FFF_FFFF,  1'b0, 5'd16);
        send_number(32'hFFFF_FFFF,  1'b0, 5'd1);
        wait_drain();

        // Full width: the extremes fit completely and the sign has room.
        write_place_count(5'd16);
        send_number(32'h8000_0000,  1'b0, 5'd16);
        send_number(32'h8000_0000,  1'b1, 5'd1);
        send_number(32'h7FFF_FFFF,  1'b1, 5'd8);
        send_number(32'd0,          1'b0, 5'd16);
        send_number(-32'sd987654321, 1'b1, 5'd10);
        send_number(32'd1,          1'b1, 5'd15);
        wait_drain();

        // A count of zero behaves as a single place: the sign never fits.
        write_place_count(5'd0);
        send_number(-32'sd7,        1'b1, 5'd1);
        send_number(32'd0,          1'b0, 5'd1);
        send_number(32'd42,         1'b0, 5'd2);
        send_number(32'hFFFF_FFFF,  1'b1, 5'd0);
        wait_drain();

        // Random phases. The first three idle the sender less than the
        // receiver, the next three the other way round, the last two not at
        // all. The long hold-off falls into the sixteen-place phase, where
        // every number produces the most output.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 3)
            begin
                send_idle_pct  = 59;
                recv_stall_pct = 23;
            end
            else if (phase == 6)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_place_count(PHASE_COUNT[phase]);
            if (phase == 3)
            begin
                fork
                    hold_receiver(300);
                join_none
            end
            run_random(ITEMS_PER_PHASE);
            wait_drain();
        end

        // This margin lets any stray output after the last place show up.
        repeat (20) @(posedge clk);

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d display places never arrived", sb.pending()));
        $display("Covered %0d numbers and %0d display places, digit counts 0 to 31,",
                 sb.numbers_seen, sb.places_checked);
        $display("with blank and zero fill, both signs, every point position and a long stall.");
        if (sb.mismatches == 0)
            $display("tb_signed_decimal_digit_formatter OK");
        else
            $display("tb_signed_decimal_digit_formatter NOT OK");
        $finish;
    end

    // Far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d display places still expected", sb.pending());
        $display("tb_signed_decimal_digit_formatter NOT OK");
        $finish;
    end

endmodule
